>>> rtl/button_press_hold_classifier_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the button press classifier
// Shared property forms for implication checks on the block clock.
// ---------------------------------------------------------------------------
`ifndef BUTTON_PRESS_HOLD_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_PRESS_HOLD_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define BPHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bphc assertion failed");

// next-cycle implication
`define BPHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bphc assertion failed");

`endif

>>> rtl/bphc_pkg.sv
// ---------------------------------------------------------------------------
// Button press classifier package
// Register map, event codes, fixed constants and divider request and response types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bphc_pkg;

  localparam int unsigned CFG_AW = 5;

  localparam logic [2:0] REG_SWITCH_MODE = 3'd0;
  localparam logic [2:0] REG_ACTIVE_HIGH = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [2:0] REG_TIMEOUT     = 3'd3;
  localparam logic [2:0] REG_LONG_PUSH   = 3'd4;
  localparam logic [2:0] REG_CHECK       = 3'd5;
  localparam logic [2:0] REG_FAST_CHECK  = 3'd6;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_HOLD    = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  localparam logic [7:0] SETUP_PRESSES = 8'd10;
  localparam logic [7:0] COUNT_MAX     = 8'd255;
  localparam logic [3:0] MAX_LEVEL     = 4'd3;
  localparam logic [3:0] NO_LEVEL      = 4'd15;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic        rem_nz;
  } div_rsp_t;

endpackage

>>> rtl/bphc_if.sv
// ---------------------------------------------------------------------------
// Button press classifier channels
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bphc_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] now_ms;
  logic        pin_level;

  modport source (output valid, output op, output now_ms, output pin_level, input ready);
  modport sink   (input valid, input op, input now_ms, input pin_level, output ready);
endinterface

interface bphc_result_if;
  logic       valid;
  logic       ready;
  logic       light_toggle;
  logic [1:0] event_kind;
  logic [7:0] hold_units;
  logic [7:0] press_count;
  logic       setup_request;

  modport source (output valid, output light_toggle, output event_kind, output hold_units,
                  output press_count, output setup_request, input ready);
  modport sink   (input valid, input light_toggle, input event_kind, input hold_units,
                  input press_count, input setup_request, output ready);
endinterface

>>> rtl/bphc_div.sv
// ---------------------------------------------------------------------------
// Button press classifier divider
// Restoring 32 by 16 bit divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bphc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bphc_pkg::div_req_t req_i,
  output bphc_pkg::div_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [15:0] rem_q;
  logic [31:0] quot_q;
  logic [15:0] dvs_q;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        fits;

  assign trial = {rem_q, quot_q[31]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quot_q <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q  <= fits ? diff[15:0] : trial[15:0];
        quot_q <= {quot_q[30:0], fits};
        cnt_q  <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quot_q;
  assign rsp_o.rem_nz = rem_q != 16'd0;

endmodule

>>> rtl/button_press_hold_classifier_core.sv
// ---------------------------------------------------------------------------
// Button press classifier core
// Takes time ticks and pin edge events, each with a millisecond timestamp,
// and gives one result beat per item. Edges outside the debounce window
// toggle the light and count rapid presses; ticks poll a held push button
// for hold levels 1 to 3 and report the held time in long-push units on
// release after a long hold; ten rapid presses followed by a quiet timeout
// raise the setup request. One item at a time: an edge, or a tick without a
// poll of a held or released button, goes through S_DIFF, S_EVAL and S_OUT;
// such a poll also waits in S_DIV and S_FIN on the 32-step divider that
// splits the held time into long-push units. Registers sit on an APB-style
// port at byte address 4 times the register index.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_press_hold_classifier_core_defines.svh"

module button_press_hold_classifier_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bphc_item_if.sink                    item_i,
  bphc_result_if.source                result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bphc_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_EVAL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_e;

  state_e state_q;

  logic        switch_mode_q;
  logic        active_high_q;
  logic [15:0] debounce_q;
  logic [15:0] timeout_q;
  logic [15:0] long_push_q;
  logic [15:0] check_q;
  logic [15:0] fast_q;

  logic        pressed_q;
  logic [31:0] press_time_q;
  logic [31:0] debounce_time_q;
  logic [31:0] last_check_q;
  logic [7:0]  press_cnt_q;
  logic [3:0]  reported_q;

  logic        op_q;
  logic [31:0] now_q;
  logic        pin_q;
  logic [31:0] held_q;
  logic [31:0] dbc_q;
  logic [31:0] chk_q;
  logic        hold_mode_q;

  logic        w_toggle_q;
  logic [1:0]  w_kind_q;
  logic [7:0]  w_units_q;
  logic        w_setup_q;

  logic        out_valid_q;
  logic        res_toggle_q;
  logic [1:0]  res_kind_q;
  logic [7:0]  res_units_q;
  logic [7:0]  res_count_q;
  logic        res_setup_q;

  bphc_pkg::div_req_t div_req;
  bphc_pkg::div_rsp_t div_rsp;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        poll;
  logic        pin_pressed;
  logic [31:0] fast_sched;
  logic        lp_zero;
  logic        gt1;
  logic        gt2;
  logic        gt3;
  logic [3:0]  level;
  logic [7:0]  units_sat;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[bphc_pkg::CFG_AW-1:2];
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      bphc_pkg::REG_SWITCH_MODE: prdata = {31'd0, switch_mode_q};
      bphc_pkg::REG_ACTIVE_HIGH: prdata = {31'd0, active_high_q};
      bphc_pkg::REG_DEBOUNCE:    prdata = {16'd0, debounce_q};
      bphc_pkg::REG_TIMEOUT:     prdata = {16'd0, timeout_q};
      bphc_pkg::REG_LONG_PUSH:   prdata = {16'd0, long_push_q};
      bphc_pkg::REG_CHECK:       prdata = {16'd0, check_q};
      bphc_pkg::REG_FAST_CHECK:  prdata = {16'd0, fast_q};
      default:                   prdata = 32'd0;
    endcase
  end

  assign poll        = !switch_mode_q && (chk_q > {16'd0, check_q});
  assign pin_pressed = pin_q == active_high_q;
  assign fast_sched  = now_q - {16'd0, check_q} + {16'd0, fast_q};

  assign div_req.start    = (state_q == S_EVAL) && !op_q && poll && (pin_pressed || pressed_q);
  assign div_req.dividend = held_q;
  assign div_req.divisor  = long_push_q;

  bphc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // held > i * long_push from quotient and remainder
  assign lp_zero = long_push_q == 16'd0;
  assign gt1 = lp_zero ? (held_q != 32'd0)
             : (div_rsp.quot > 32'd1) || ((div_rsp.quot == 32'd1) && div_rsp.rem_nz);
  assign gt2 = lp_zero ? (held_q != 32'd0)
             : (div_rsp.quot > 32'd2) || ((div_rsp.quot == 32'd2) && div_rsp.rem_nz);
  assign gt3 = lp_zero ? (held_q != 32'd0)
             : (div_rsp.quot > 32'd3) || ((div_rsp.quot == 32'd3) && div_rsp.rem_nz);
  assign level = gt3 ? bphc_pkg::MAX_LEVEL : gt2 ? 4'd2 : gt1 ? 4'd1 : 4'd0;
  assign units_sat = (lp_zero || (div_rsp.quot > 32'd255)) ? bphc_pkg::COUNT_MAX
                   : div_rsp.quot[7:0];

  assign item_i.ready           = state_q == S_IDLE;
  assign result_o.valid         = out_valid_q;
  assign result_o.light_toggle  = res_toggle_q;
  assign result_o.event_kind    = res_kind_q;
  assign result_o.hold_units    = res_units_q;
  assign result_o.press_count   = res_count_q;
  assign result_o.setup_request = res_setup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      switch_mode_q   <= 1'b0;
      active_high_q   <= 1'b0;
      debounce_q      <= 16'd50;
      timeout_q       <= 16'd1000;
      long_push_q     <= 16'd1000;
      check_q         <= 16'd1000;
      fast_q          <= 16'd100;
      pressed_q       <= 1'b0;
      press_time_q    <= '0;
      debounce_time_q <= '0;
      last_check_q    <= '0;
      press_cnt_q     <= '0;
      reported_q      <= bphc_pkg::NO_LEVEL;
      op_q            <= 1'b0;
      now_q           <= '0;
      pin_q           <= 1'b0;
      held_q          <= '0;
      dbc_q           <= '0;
      chk_q           <= '0;
      hold_mode_q     <= 1'b0;
      w_toggle_q      <= 1'b0;
      w_kind_q        <= bphc_pkg::KIND_NONE;
      w_units_q       <= '0;
      w_setup_q       <= 1'b0;
      out_valid_q     <= 1'b0;
      res_toggle_q    <= 1'b0;
      res_kind_q      <= bphc_pkg::KIND_NONE;
      res_units_q     <= '0;
      res_count_q     <= '0;
      res_setup_q     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          bphc_pkg::REG_SWITCH_MODE: switch_mode_q <= pwdata[0];
          bphc_pkg::REG_ACTIVE_HIGH: active_high_q <= pwdata[0];
          bphc_pkg::REG_DEBOUNCE:    debounce_q    <= pwdata[15:0];
          bphc_pkg::REG_TIMEOUT:     timeout_q     <= pwdata[15:0];
          bphc_pkg::REG_LONG_PUSH:   long_push_q   <= pwdata[15:0];
          bphc_pkg::REG_CHECK:       check_q       <= pwdata[15:0];
          bphc_pkg::REG_FAST_CHECK:  fast_q        <= pwdata[15:0];
          default: ;
        endcase
      end

      if (out_valid_q && result_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (item_i.valid) begin
            op_q       <= item_i.op;
            now_q      <= item_i.now_ms;
            pin_q      <= item_i.pin_level;
            w_toggle_q <= 1'b0;
            w_kind_q   <= bphc_pkg::KIND_NONE;
            w_units_q  <= '0;
            w_setup_q  <= 1'b0;
            state_q    <= S_DIFF;
          end
        end
        S_DIFF: begin
          held_q  <= now_q - press_time_q;
          dbc_q   <= now_q - debounce_time_q;
          chk_q   <= now_q - last_check_q;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          state_q <= div_req.start ? S_DIV : S_OUT;
          if (op_q) begin
            if (!switch_mode_q) begin
              pressed_q <= 1'b1;
            end
            if (dbc_q > {16'd0, debounce_q}) begin
              w_toggle_q <= 1'b1;
              w_kind_q   <= bphc_pkg::KIND_PRESS;
              if (held_q < {16'd0, timeout_q}) begin
                if (press_cnt_q != bphc_pkg::COUNT_MAX) begin
                  press_cnt_q <= press_cnt_q + 8'd1;
                end
              end else begin
                press_cnt_q <= 8'd1;
              end
              press_time_q <= now_q;
              reported_q   <= 4'd0;
              last_check_q <= fast_sched;
            end
            debounce_time_q <= now_q;
          end else begin
            w_setup_q <= (press_cnt_q >= bphc_pkg::SETUP_PRESSES)
                         && (held_q > {16'd0, timeout_q});
            if (poll) begin
              hold_mode_q <= pin_pressed;
              if (pin_pressed) begin
                last_check_q    <= fast_sched;
                debounce_time_q <= now_q;
              end else begin
                last_check_q <= now_q;
                if (pressed_q) begin
                  pressed_q <= 1'b0;
                end
              end
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (hold_mode_q) begin
            if ((level != 4'd0) && (level != reported_q)) begin
              reported_q <= level;
              w_kind_q   <= bphc_pkg::KIND_HOLD;
              w_units_q  <= {4'd0, level};
            end
          end else if (gt3) begin
            w_kind_q   <= bphc_pkg::KIND_RELEASE;
            w_units_q  <= units_sat;
            reported_q <= bphc_pkg::NO_LEVEL;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || result_o.ready) begin
            out_valid_q  <= 1'b1;
            res_toggle_q <= w_toggle_q;
            res_kind_q   <= w_kind_q;
            res_units_q  <= w_units_q;
            res_count_q  <= press_cnt_q;
            res_setup_q  <= w_setup_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `BPHC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, item_i.valid && item_i.ready, !item_i.ready)
  `BPHC_ASSERT_IMPL(a_div_done_in_div, clk_i, rst_ni, div_rsp.done, state_q == S_DIV)
  `BPHC_ASSERT_IMPL(a_toggle_is_press, clk_i, rst_ni, out_valid_q, res_toggle_q == (res_kind_q == bphc_pkg::KIND_PRESS))
  `BPHC_ASSERT_IMPL(a_level_range, clk_i, rst_ni, 1'b1, (reported_q <= bphc_pkg::MAX_LEVEL) || (reported_q == bphc_pkg::NO_LEVEL))

endmodule

>>> tb/sv/button_press_hold_classifier_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button press classifier core testbench
// Drives ticks and pin edges through the item channel under random sender
// gaps and receiver stalls, predicts every result beat from a local model of
// debounce, rapid-press counting, hold polling and release timing, and checks
// each beat in order. Runs directed cases first, then random press, hold,
// bounce and noise sequences over several register settings.
// ---------------------------------------------------------------------------

module button_press_hold_classifier_core_test;

  localparam logic        OP_TICK        = 1'b0;
  localparam logic        OP_EDGE        = 1'b1;
  localparam int unsigned SHOWN_MAX      = 10;
  localparam int unsigned LATENCY_CYCLES = 40;

  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic        pin_level;
  } button_item_t;

  typedef struct packed {
    logic       light_toggle;
    logic [1:0] event_kind;
    logic [7:0] hold_units;
    logic [7:0] press_count;
    logic       setup_request;
  } button_report_t;

  typedef struct packed {
    logic        switch_mode;
    logic        active_high;
    logic [15:0] debounce_ms;
    logic [15:0] timeout_ms;
    logic [15:0] long_push_ms;
    logic [15:0] check_ms;
    logic [15:0] fast_ms;
  } button_cfg_t;

  typedef struct {
    button_item_t item;
    bit           drain;
  } pin_event_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bphc_pkg::CFG_AW-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  bphc_item_if   item_bus();
  bphc_result_if report_bus();

  button_press_hold_classifier_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (report_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // model of the block
  button_cfg_t model_cfg;
  logic        held_flag;
  logic [31:0] press_stamp;
  logic [31:0] bounce_stamp;
  logic [31:0] poll_stamp;
  logic [7:0]  rapid_presses;
  logic [3:0]  shown_level;

  // stimulus side
  pin_event_t     pin_events[$];
  button_report_t predicted_reports[$];
  button_cfg_t    gen_cfg;
  int unsigned    gen_debounce, gen_timeout, gen_long, gen_check, gen_fast;
  logic [31:0]    stamp_ms;
  bit             drain_next;
  int unsigned    phase_items;

  logic        item_beat;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          idle_on;
  int unsigned stretch_cnt;

  int unsigned error_count;
  int unsigned items_taken;
  int unsigned settings_used;
  int unsigned presses_seen, holds_seen, releases_seen, setups_seen;

  task automatic reset_model();
    model_cfg     = '{switch_mode: 1'b0, active_high: 1'b0, debounce_ms: 16'd50,
                      timeout_ms: 16'd1000, long_push_ms: 16'd1000, check_ms: 16'd1000,
                      fast_ms: 16'd100};
    held_flag     = 1'b0;
    press_stamp   = '0;
    bounce_stamp  = '0;
    poll_stamp    = '0;
    rapid_presses = '0;
    shown_level   = bphc_pkg::NO_LEVEL;
  endtask

  function automatic void apply_register(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      bphc_pkg::REG_SWITCH_MODE: model_cfg.switch_mode  = data[0];
      bphc_pkg::REG_ACTIVE_HIGH: model_cfg.active_high  = data[0];
      bphc_pkg::REG_DEBOUNCE:    model_cfg.debounce_ms  = data[15:0];
      bphc_pkg::REG_TIMEOUT:     model_cfg.timeout_ms   = data[15:0];
      bphc_pkg::REG_LONG_PUSH:   model_cfg.long_push_ms = data[15:0];
      bphc_pkg::REG_CHECK:       model_cfg.check_ms     = data[15:0];
      bphc_pkg::REG_FAST_CHECK:  model_cfg.fast_ms      = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic button_report_t classify_item(input button_item_t it);
    button_report_t r;
    logic [31:0]    held;
    logic [31:0]    units;
    logic [31:0]    lp;
    logic [31:0]    chk;
    logic [31:0]    fst;
    int unsigned    lvl;
    bit             found;
    r     = '0;
    lp    = {16'd0, model_cfg.long_push_ms};
    chk   = {16'd0, model_cfg.check_ms};
    fst   = {16'd0, model_cfg.fast_ms};
    held  = it.now_ms - press_stamp;
    if (it.op == OP_EDGE) begin
      if (!model_cfg.switch_mode) held_flag = 1'b1;
      if (it.now_ms - bounce_stamp > {16'd0, model_cfg.debounce_ms}) begin
        r.light_toggle = 1'b1;
        r.event_kind   = bphc_pkg::KIND_PRESS;
        if (held < {16'd0, model_cfg.timeout_ms}) begin
          if (rapid_presses != bphc_pkg::COUNT_MAX) rapid_presses = rapid_presses + 8'd1;
        end else begin
          rapid_presses = 8'd1;
        end
        press_stamp = it.now_ms;
        shown_level = 4'd0;
        poll_stamp  = it.now_ms - chk + fst;
      end
      bounce_stamp = it.now_ms;
    end else begin
      r.setup_request = (rapid_presses >= bphc_pkg::SETUP_PRESSES) &&
                        (held > {16'd0, model_cfg.timeout_ms});
      if (!model_cfg.switch_mode && (it.now_ms - poll_stamp > chk)) begin
        poll_stamp = it.now_ms;
        if (it.pin_level == model_cfg.active_high) begin
          found = 1'b0;
          for (lvl = 32'(bphc_pkg::MAX_LEVEL); lvl > 0; lvl--) begin
            if (!found && held > lvl * lp) begin
              found = 1'b1;
              if (shown_level != lvl[3:0]) begin
                shown_level  = lvl[3:0];
                r.event_kind = bphc_pkg::KIND_HOLD;
                r.hold_units = lvl[7:0];
              end
            end
          end
          poll_stamp   = it.now_ms - chk + fst;
          bounce_stamp = it.now_ms;
        end else if (held_flag) begin
          held_flag = 1'b0;
          if (held > {28'd0, bphc_pkg::MAX_LEVEL} * lp) begin
            units        = (lp == 32'd0) ? 32'd255 : held / lp;
            r.event_kind = bphc_pkg::KIND_RELEASE;
            r.hold_units = (units > 32'd255) ? bphc_pkg::COUNT_MAX : units[7:0];
            shown_level  = bphc_pkg::NO_LEVEL;
          end
        end
      end
    end
    r.press_count = rapid_presses;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // monitor: check result beats, predict on item beats, track register writes
  always @(posedge clk_i) begin : monitor
    button_report_t got;
    button_report_t want;
    if (!rst_ni) begin
      item_beat <= 1'b0;
    end else begin
      item_beat <= item_bus.valid && item_bus.ready;
      if (psel && penable && pwrite && pready) begin
        apply_register(paddr[bphc_pkg::CFG_AW-1:2], pwdata);
      end
      if (report_bus.valid && report_bus.ready) begin
        got = {report_bus.light_toggle, report_bus.event_kind, report_bus.hold_units,
               report_bus.press_count, report_bus.setup_request};
        if (predicted_reports.size() == 0) begin
          error_count++;
          if (error_count <= SHOWN_MAX)
            $display("%0t: result beat with none expected: toggle %0b kind %0d units %0d count %0d setup %0b",
                     $time, got.light_toggle, got.event_kind, got.hold_units, got.press_count,
                     got.setup_request);
        end else begin
          want = predicted_reports.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= SHOWN_MAX) begin
              $display("%0t: mismatch exp toggle %0b kind %0d units %0d count %0d setup %0b",
                       $time, want.light_toggle, want.event_kind, want.hold_units,
                       want.press_count, want.setup_request);
              $display("%0t:          got toggle %0b kind %0d units %0d count %0d setup %0b",
                       $time, got.light_toggle, got.event_kind, got.hold_units,
                       got.press_count, got.setup_request);
            end
          end
        end
        case (got.event_kind)
          bphc_pkg::KIND_PRESS:   presses_seen++;
          bphc_pkg::KIND_HOLD:    holds_seen++;
          bphc_pkg::KIND_RELEASE: releases_seen++;
          default: ;
        endcase
        if (got.setup_request === 1'b1) setups_seen++;
      end
      if (item_bus.valid && item_bus.ready) begin
        predicted_reports.push_back(classify_item({item_bus.op, item_bus.now_ms,
                                                   item_bus.pin_level}));
        items_taken++;
      end
    end
  end

  // driver: present queued items, hold until taken, insert gaps
  always @(negedge clk_i) begin : driver
    pin_event_t next_event;
    if (!rst_ni) begin
      item_bus.valid <= 1'b0;
      gap_left       <= 0;
    end else if (!item_bus.valid || item_beat) begin
      if (gap_left != 0) begin
        item_bus.valid <= 1'b0;
        gap_left       <= gap_left - 1;
      end else if (pin_events.size() == 0 ||
                   (pin_events[0].drain && predicted_reports.size() != 0)) begin
        item_bus.valid <= 1'b0;
      end else begin
        next_event         = pin_events.pop_front();
        item_bus.valid     <= 1'b1;
        item_bus.op        <= next_event.item.op;
        item_bus.now_ms    <= next_event.item.now_ms;
        item_bus.pin_level <= next_event.item.pin_level;
        gap_left           <= idle_on ? idle_len() : 0;
      end
    end
  end

  // receiver: stall the result channel at random, in stretches
  always @(negedge clk_i) begin : receiver
    if (!rst_ni) begin
      report_bus.ready <= 1'b0;
      stall_left       <= 0;
      idle_on          <= 1'b0;
      stretch_cnt      <= 0;
    end else begin
      stretch_cnt <= stretch_cnt + 1;
      if (stretch_cnt % 150 == 149) idle_on <= ($urandom_range(0, 3) != 0);
      if (stall_left != 0) begin
        report_bus.ready <= 1'b0;
        stall_left       <= stall_left - 1;
      end else begin
        report_bus.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) stall_left <= idle_len();
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_setup(input button_cfg_t c);
    logic [15:0] junk;
    junk = $urandom_range(0, 1) ? 16'($urandom()) : 16'd0;
    write_reg(bphc_pkg::REG_SWITCH_MODE, {junk, junk[14:0], c.switch_mode});
    write_reg(bphc_pkg::REG_ACTIVE_HIGH, {junk, junk[14:0], c.active_high});
    write_reg(bphc_pkg::REG_DEBOUNCE,    {junk, c.debounce_ms});
    write_reg(bphc_pkg::REG_TIMEOUT,     {junk, c.timeout_ms});
    write_reg(bphc_pkg::REG_LONG_PUSH,   {junk, c.long_push_ms});
    write_reg(bphc_pkg::REG_CHECK,       {junk, c.check_ms});
    write_reg(bphc_pkg::REG_FAST_CHECK,  {junk, c.fast_ms});
    gen_cfg      = c;
    gen_debounce = 32'(c.debounce_ms);
    gen_timeout  = 32'(c.timeout_ms);
    gen_long     = 32'(c.long_push_ms);
    gen_check    = 32'(c.check_ms);
    gen_fast     = 32'(c.fast_ms);
    settings_used++;
  endtask

  task automatic wait_idle();
    while (pin_events.size() != 0 || item_bus.valid || predicted_reports.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic queue_event(input logic op, input logic [31:0] now, input logic pin);
    pin_event_t e;
    e.item     = '{op: op, now_ms: now, pin_level: pin};
    e.drain    = drain_next;
    drain_next = 1'b0;
    pin_events.push_back(e);
    phase_items++;
  endtask

  task automatic add_hold_sequence();
    logic        down;
    int unsigned target;
    int unsigned step;
    int unsigned ticks;
    down = gen_cfg.active_high;
    stamp_ms += gen_debounce + 1 + $urandom_range(0, 20);
    queue_event(OP_EDGE, stamp_ms, 1'($urandom_range(0, 1)));
    target = $urandom_range(0, 5 * gen_long + 10);
    ticks  = $urandom_range(1, 10);
    step   = target / ticks + 1;
    repeat (ticks) begin
      stamp_ms += $urandom_range(1, 2 * step);
      if ($urandom_range(0, 9) == 0) begin
        stamp_ms += $urandom_range(0, gen_debounce);
        queue_event(OP_EDGE, stamp_ms, 1'($urandom_range(0, 1)));
      end
      queue_event(OP_TICK, stamp_ms, down);
    end
    if ($urandom_range(0, 1)) begin
      stamp_ms += $urandom_range(0, gen_debounce + 5);
      queue_event(OP_EDGE, stamp_ms, !down);
    end
    stamp_ms += gen_fast + $urandom_range(1, 20);
    queue_event(OP_TICK, stamp_ms, !down);
    if ($urandom_range(0, 1)) begin
      stamp_ms += $urandom_range(1, gen_check + gen_fast + 2);
      queue_event(OP_TICK, stamp_ms, !down);
    end
  endtask

  task automatic add_press_burst(input int unsigned presses);
    int unsigned lo;
    int unsigned hi;
    if (gen_debounce + 2 < gen_timeout) begin
      lo = gen_debounce + 1;
      hi = gen_timeout - 1;
    end else begin
      lo = 1;
      hi = gen_debounce + 2;
    end
    repeat (presses) begin
      stamp_ms += $urandom_range(lo, hi);
      queue_event(OP_EDGE, stamp_ms, 1'($urandom_range(0, 1)));
    end
    stamp_ms += $urandom_range(0, gen_timeout);
    queue_event(OP_TICK, stamp_ms, 1'($urandom_range(0, 1)));
    stamp_ms += gen_timeout + $urandom_range(1, 50);
    queue_event(OP_TICK, stamp_ms, !gen_cfg.active_high);
  endtask

  task automatic fill_random_phase(input int unsigned goal);
    int unsigned pick;
    bit          drain_set;
    drain_set   = 1'b0;
    phase_items = 0;
    pick = $urandom_range(0, 3);
    if (pick == 0) stamp_ms = $urandom();
    else if (pick == 1) stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
    while (phase_items < goal) begin
      if (!drain_set && phase_items >= goal / 2) begin
        drain_next = 1'b1;
        drain_set  = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        add_hold_sequence();
      end else if (pick < 60) begin
        add_press_burst(($urandom_range(0, 9) < 7) ? $urandom_range(10, 13)
                                                   : $urandom_range(1, 9));
      end else if (pick < 78) begin
        repeat ($urandom_range(2, 5)) begin
          stamp_ms += $urandom_range(0, gen_debounce);
          queue_event(OP_EDGE, stamp_ms, 1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 2) == 0) stamp_ms = $urandom();
          else stamp_ms += $urandom_range(0, 3000);
          queue_event(1'($urandom_range(0, 1)), stamp_ms, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  function automatic logic [15:0] pick_ms(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd1;
    if (r < 14) return 16'hFFFF;
    return 16'($urandom_range(lo, hi));
  endfunction

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    button_cfg_t c;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    item_bus.valid     = 1'b0;
    item_bus.op        = OP_TICK;
    item_bus.now_ms    = '0;
    item_bus.pin_level = 1'b0;
    report_bus.ready   = 1'b0;
    item_beat          = 1'b0;
    gap_left           = 0;
    stall_left         = 0;
    idle_on            = 1'b0;
    stretch_cnt        = 0;
    drain_next         = 1'b0;
    stamp_ms           = '0;
    error_count        = 0;
    items_taken        = 0;
    settings_used      = 0;
    presses_seen       = 0;
    holds_seen         = 0;
    releases_seen      = 0;
    setups_seen        = 0;
    reset_model();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // debounce boundary, hold levels, release after long hold, short press, setup
    c = '{switch_mode: 1'b0, active_high: 1'b0, debounce_ms: 16'd50, timeout_ms: 16'd1000,
          long_push_ms: 16'd1000, check_ms: 16'd1000, fast_ms: 16'd100};
    program_setup(c);
    queue_event(OP_EDGE, 32'd10, 1'b0);
    queue_event(OP_EDGE, 32'd60, 1'b1);
    queue_event(OP_EDGE, 32'd111, 1'b0);
    queue_event(OP_TICK, 32'd212, 1'b0);
    queue_event(OP_TICK, 32'd1200, 1'b0);
    queue_event(OP_TICK, 32'd2200, 1'b0);
    queue_event(OP_TICK, 32'd3200, 1'b0);
    queue_event(OP_EDGE, 32'd3220, 1'b1);
    queue_event(OP_TICK, 32'd4700, 1'b1);
    queue_event(OP_EDGE, 32'd5000, 1'b0);
    queue_event(OP_TICK, 32'd5200, 1'b1);
    for (int k = 0; k < 10; k++) queue_event(OP_EDGE, 32'd6000 + 32'(k) * 32'd100, 1'b0);
    queue_event(OP_TICK, 32'd8000, 1'b1);
    queue_event(OP_TICK, 32'hFFFF_FFFF, 1'b0);
    wait_idle();

    // zero debounce, long push and intervals
    c = '{switch_mode: 1'b0, active_high: 1'b1, debounce_ms: 16'd0, timeout_ms: 16'd1,
          long_push_ms: 16'd0, check_ms: 16'd0, fast_ms: 16'd0};
    program_setup(c);
    queue_event(OP_EDGE, 32'd100, 1'b0);
    queue_event(OP_EDGE, 32'd100, 1'b1);
    queue_event(OP_EDGE, 32'd101, 1'b0);
    queue_event(OP_TICK, 32'd102, 1'b1);
    queue_event(OP_TICK, 32'd103, 1'b0);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      c.switch_mode = ($urandom_range(0, 3) == 0);
      c.active_high = 1'($urandom_range(0, 1));
      case (p)
        0: begin
          c.switch_mode  = 1'b0;
          c.debounce_ms  = 16'd1;
          c.timeout_ms   = 16'd1;
          c.long_push_ms = 16'd1;
          c.check_ms     = 16'd1;
          c.fast_ms      = 16'd1;
        end
        1: begin
          c.switch_mode  = 1'b0;
          c.debounce_ms  = 16'hFFFF;
          c.timeout_ms   = 16'hFFFF;
          c.long_push_ms = 16'hFFFF;
          c.check_ms     = 16'hFFFF;
          c.fast_ms      = 16'hFFFF;
        end
        3: begin
          c.switch_mode  = 1'b1;
          c.debounce_ms  = 16'd2;
          c.timeout_ms   = 16'd100;
          c.long_push_ms = pick_ms(50, 1500);
          c.check_ms     = pick_ms(100, 1500);
          c.fast_ms      = pick_ms(10, 300);
        end
        default: begin
          c.debounce_ms  = pick_ms(5, 80);
          c.timeout_ms   = pick_ms(200, 1500);
          c.long_push_ms = pick_ms(50, 1500);
          c.check_ms     = pick_ms(100, 1500);
          c.fast_ms      = pick_ms(10, 300);
        end
      endcase
      program_setup(c);
      fill_random_phase(45);
      // drive the press counter into saturation
      if (p == 3) add_press_burst(258);
      wait_idle();
    end

    repeat (LATENCY_CYCLES) @(posedge clk_i);
    $display("Covered %0d items over %0d register settings, both modes, wrapped timestamps.",
             items_taken, settings_used);
    $display("Saw %0d presses, %0d hold levels, %0d long-hold releases, %0d setup requests.",
             presses_seen, holds_seen, releases_seen, setups_seen);
    if (error_count == 0 && predicted_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
